// ===== src/ads_pkg.sv =====
// ads_pkg: shared types, constants and width helpers for the axis dead-zone scaler.
// No dependencies; imported by every module of the block.
package ads_pkg;

    // Fixed field widths
    localparam int OUT_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Quotient magnitude bits kept by the divider; beyond this the result saturates
    localparam int QUOT_W = 17;

    // Defaults and reset values
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int IN_HIGH_RST     = 1024;
    localparam int OUT_LOW_RST     = -32767;
    localparam int OUT_HIGH_RST    = 32767;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_LOW       = 3'd0,
        REG_INPUT_HIGH      = 3'd1,
        REG_DEAD_HALF_WIDTH = 3'd2,
        REG_OUTPUT_LOW      = 3'd3,
        REG_OUTPUT_HIGH     = 3'd4
    } t_cfg_idx;

    // Region codes of a result
    typedef enum logic [1:0] {
        REGION_DEAD = 2'd0,
        REGION_UP   = 2'd1,
        REGION_DOWN = 2'd2
    } t_region;

    // Per-item control travelling down the pipeline
    typedef struct packed {
        t_region region;
        logic    fault;
        logic    neg;
        logic    ovf;
    } t_meta;

    // One result item
    typedef struct packed {
        logic signed [OUT_W-1:0] position;
        t_region                 region;
        logic                    span_fault;
    } t_result;

    // Width of the signed numerator (and of its magnitude) for a sample width
    function automatic int num_width(input int sample_bits);
        num_width = sample_bits + OUT_W + 5;
    endfunction

endpackage

// ===== src/ads_front.sv =====
// ads_front: region detection, numerator products, sum, magnitude and overflow check.
// Five register stages; depends on ads_pkg.
module ads_front #(
    parameter int SAMPLE_BITS = ads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [SAMPLE_BITS-1:0]                  i_sample,
    input  logic [SAMPLE_BITS-1:0]                  i_in_low,
    input  logic [SAMPLE_BITS-1:0]                  i_in_high,
    input  logic [SAMPLE_BITS-1:0]                  i_dead,
    input  logic signed [ads_pkg::OUT_W-1:0]        i_out_low,
    input  logic signed [ads_pkg::OUT_W-1:0]        i_out_high,
    output logic                                    o_valid,
    output ads_pkg::t_meta                          o_meta,
    output logic [ads_pkg::num_width(SAMPLE_BITS)-1:0] o_mag,
    output logic [SAMPLE_BITS:0]                    o_den
);
    import ads_pkg::*;

    localparam int W1    = SAMPLE_BITS + 3;
    localparam int NUM_W = num_width(SAMPLE_BITS);
    localparam int PA_W  = OUT_W + 2 + SAMPLE_BITS;
    localparam int PB_W  = OUT_W + 1 + W1;

    // Stage 1: half-count compare against the dead zone edges
    logic signed [W1-1:0] s2, lo_x, hi_x, lo2, nn2, mid2, up2, dn2, span2, diff;
    logic                 is_up, is_dn, span_ok;
    t_meta                n_s1_meta;

    assign s2    = $signed(W1'({i_sample, 1'b0}));
    assign lo_x  = $signed(W1'(i_in_low));
    assign hi_x  = $signed(W1'(i_in_high));
    assign lo2   = $signed(W1'({i_in_low, 1'b0}));
    assign nn2   = $signed(W1'({i_dead, 1'b0}));
    assign mid2  = lo_x + hi_x;
    assign up2   = mid2 + nn2;
    assign dn2   = mid2 - nn2;
    assign span2 = hi_x - lo_x - nn2;
    assign is_up = s2 > up2;
    assign is_dn = s2 < dn2;
    assign span_ok = !span2[W1-1] && (span2 != W1'(0));
    assign diff  = is_up ? (s2 - up2) : (s2 - lo2);

    always_comb begin
        n_s1_meta        = '0;
        n_s1_meta.region = is_up ? REGION_UP : (is_dn ? REGION_DOWN : REGION_DEAD);
        n_s1_meta.fault  = (is_up || is_dn) && !span_ok;
    end

    logic                    r_s1_valid;
    t_meta                   r_s1_meta;
    logic signed [W1-1:0]    r_s1_diff;
    logic [SAMPLE_BITS-1:0]  r_s1_span;

    // Stage 2: the two products of the numerator
    logic signed [OUT_W:0]  osum, odiff, base;
    logic signed [PA_W-1:0] prod_a;
    logic signed [PB_W-1:0] prod_b;

    assign osum   = (OUT_W+1)'(i_out_low) + (OUT_W+1)'(i_out_high);
    assign odiff  = (OUT_W+1)'(i_out_high) - (OUT_W+1)'(i_out_low);
    assign base   = (r_s1_meta.region == REGION_UP) ? osum : $signed({i_out_low, 1'b0});
    assign prod_a = base * $signed({1'b0, r_s1_span});
    assign prod_b = odiff * r_s1_diff;

    logic                    r_s2_valid;
    t_meta                   r_s2_meta;
    logic signed [NUM_W-1:0] r_s2_a, r_s2_b;
    logic [SAMPLE_BITS:0]    r_s2_den;

    // Stage 3: numerator sum
    logic                    r_s3_valid;
    t_meta                   r_s3_meta;
    logic signed [NUM_W-1:0] r_s3_num;
    logic [SAMPLE_BITS:0]    r_s3_den;

    // Stage 4: sign and magnitude
    logic                    num_neg;
    t_meta                   n_s4_meta;
    logic                    r_s4_valid;
    t_meta                   r_s4_meta;
    logic [NUM_W-1:0]        r_s4_mag;
    logic [SAMPLE_BITS:0]    r_s4_den;

    assign num_neg = r_s3_num[NUM_W-1];

    always_comb begin
        n_s4_meta     = r_s3_meta;
        n_s4_meta.neg = num_neg;
    end

    // Stage 5: quotient overflow check
    logic                    ovf;
    t_meta                   n_s5_meta;
    logic                    r_s5_valid;
    t_meta                   r_s5_meta;
    logic [NUM_W-1:0]        r_s5_mag;
    logic [SAMPLE_BITS:0]    r_s5_den;

    assign ovf = r_s4_mag >= (NUM_W'(r_s4_den) << QUOT_W);

    always_comb begin
        n_s5_meta     = r_s4_meta;
        n_s5_meta.ovf = ovf;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_meta <= n_s1_meta;
            r_s1_diff <= diff;
            r_s1_span <= span2[SAMPLE_BITS-1:0];

            r_s2_meta <= r_s1_meta;
            r_s2_a    <= NUM_W'(prod_a);
            r_s2_b    <= NUM_W'(prod_b);
            r_s2_den  <= {r_s1_span, 1'b0};

            r_s3_meta <= r_s2_meta;
            r_s3_num  <= r_s2_a + r_s2_b;
            r_s3_den  <= r_s2_den;

            r_s4_meta <= n_s4_meta;
            r_s4_mag  <= num_neg ? NUM_W'(-r_s3_num) : NUM_W'(r_s3_num);
            r_s4_den  <= r_s3_den;

            r_s5_meta <= n_s5_meta;
            r_s5_mag  <= r_s4_mag;
            r_s5_den  <= r_s4_den;
        end
    end

    assign o_valid = r_s5_valid;
    assign o_meta  = r_s5_meta;
    assign o_mag   = r_s5_mag;
    assign o_den   = r_s5_den;

endmodule

// ===== src/ads_div.sv =====
// ads_div: pipelined restoring divider, one quotient bit per register stage.
// Depends on ads_pkg; dividend must be below divisor shifted by QUOT_W unless flagged.
module ads_div #(
    parameter int SAMPLE_BITS = ads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  ads_pkg::t_meta                             i_meta,
    input  logic [ads_pkg::num_width(SAMPLE_BITS)-1:0] i_mag,
    input  logic [SAMPLE_BITS:0]                       i_den,
    output logic                                       o_valid,
    output ads_pkg::t_meta                             o_meta,
    output logic [ads_pkg::QUOT_W-1:0]                 o_quo
);
    import ads_pkg::*;

    localparam int NUM_W = num_width(SAMPLE_BITS);

    // Stage registers, stage j resolves quotient bit QUOT_W-1-j
    logic                   r_valid [0:QUOT_W-1];
    t_meta                  r_meta  [0:QUOT_W-1];
    logic [NUM_W-1:0]       r_rem   [0:QUOT_W-1];
    logic [QUOT_W-1:0]      r_quo   [0:QUOT_W-1];
    logic [SAMPLE_BITS:0]   r_den   [0:QUOT_W-1];

    // Stage inputs: entry 0 from the front end, the rest from the previous stage
    wire                    w_valid [0:QUOT_W-1];
    t_meta                  w_meta  [0:QUOT_W-1];
    wire [NUM_W-1:0]        w_rem   [0:QUOT_W-1];
    wire [QUOT_W-1:0]       w_quo   [0:QUOT_W-1];
    wire [SAMPLE_BITS:0]    w_den   [0:QUOT_W-1];

    assign w_valid[0] = i_valid;
    assign w_meta[0]  = i_meta;
    assign w_rem[0]   = i_mag;
    assign w_quo[0]   = '0;
    assign w_den[0]   = i_den;

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        localparam int K = QUOT_W - 1 - j;

        logic [NUM_W-1:0] shifted;
        logic             take;

        if (j > 0) begin : g_link
            assign w_valid[j] = r_valid[j-1];
            assign w_meta[j]  = r_meta[j-1];
            assign w_rem[j]   = r_rem[j-1];
            assign w_quo[j]   = r_quo[j-1];
            assign w_den[j]   = r_den[j-1];
        end

        // Trial subtract of the divisor at this bit weight
        assign shifted = NUM_W'(w_den[j]) << K;
        assign take    = w_rem[j] >= shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= w_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[j] <= w_meta[j];
                r_den[j]  <= w_den[j];
                r_rem[j]  <= take ? (w_rem[j] - shifted) : w_rem[j];
                r_quo[j]  <= w_quo[j] | (QUOT_W'(take) << K);
            end
        end
    end

    assign o_valid = r_valid[QUOT_W-1];
    assign o_meta  = r_meta[QUOT_W-1];
    assign o_quo   = r_quo[QUOT_W-1];

endmodule

// ===== src/ads_out.sv =====
// ads_out: quotient sign, segment clamp, 16-bit saturation and the output skid buffer.
// Two register stages plus one skid entry; depends on ads_pkg.
module ads_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  ads_pkg::t_meta                   i_meta,
    input  logic [ads_pkg::QUOT_W-1:0]       i_quo,
    input  logic signed [ads_pkg::OUT_W-1:0] i_out_low,
    input  logic signed [ads_pkg::OUT_W-1:0] i_out_high,
    input  logic                             i_ready,
    output logic                             o_en,
    output logic                             o_valid,
    output ads_pkg::t_result                 o_result
);
    import ads_pkg::*;

    localparam logic signed [QUOT_W:0] POS_MAX = (QUOT_W+1)'(2**(OUT_W-1) - 1);
    localparam logic signed [QUOT_W:0] POS_MIN = (QUOT_W+1)'(-(2**(OUT_W-1)));

    logic    r_out_valid, r_sk_valid;
    t_result r_out, r_sk;

    assign o_en = !r_sk_valid;

    // Stage F1: apply overflow saturation and sign to the quotient
    logic [QUOT_W-1:0]        qmag;
    logic signed [QUOT_W:0]   qsgn;
    logic                     r_f1_valid;
    t_meta                    r_f1_meta;
    logic signed [QUOT_W:0]   r_f1_q;

    assign qmag = i_meta.ovf ? '1 : i_quo;
    assign qsgn = i_meta.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (o_en) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_f1_meta <= i_meta;
            r_f1_q    <= qsgn;
        end
    end

    // Stage F2: output middle, one-sided clamp, saturation
    logic signed [OUT_W:0]    osum, ohalf;
    logic signed [QUOT_W:0]   ol_x, oh_x, clamped;
    logic signed [OUT_W-1:0]  omid, sat;
    t_result                  n_res;

    assign osum  = (OUT_W+1)'(i_out_low) + (OUT_W+1)'(i_out_high);
    assign ohalf = (osum + $signed({{OUT_W{1'b0}}, osum[OUT_W]})) >>> 1;
    assign omid  = ohalf[OUT_W-1:0];
    assign ol_x  = (QUOT_W+1)'(i_out_low);
    assign oh_x  = (QUOT_W+1)'(i_out_high);

    always_comb begin
        case (r_f1_meta.region)
            REGION_UP:   clamped = (r_f1_q > oh_x) ? oh_x : r_f1_q;
            REGION_DOWN: clamped = (r_f1_q < ol_x) ? ol_x : r_f1_q;
            default:     clamped = r_f1_q;
        endcase
    end

    always_comb begin
        if (clamped > POS_MAX) begin
            sat = POS_MAX[OUT_W-1:0];
        end else if (clamped < POS_MIN) begin
            sat = POS_MIN[OUT_W-1:0];
        end else begin
            sat = clamped[OUT_W-1:0];
        end
    end

    always_comb begin
        n_res.region     = r_f1_meta.region;
        n_res.span_fault = r_f1_meta.fault;
        if (r_f1_meta.fault || (r_f1_meta.region == REGION_DEAD)) begin
            n_res.position = omid;
        end else begin
            n_res.position = sat;
        end
    end

    // Output register with one skid entry; upstream halts only when the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (i_ready) begin
                r_out      <= r_sk;
                r_sk_valid <= 1'b0;
            end
        end else if (r_f1_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end else begin
                r_sk       <= n_res;
                r_sk_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held without a waiting output");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid filled although the output was free");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !i_ready) |=> (r_sk_valid && $stable(r_sk)))
        else $error("skid entry lost or changed under stall");

    a_fault_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.span_fault) |-> (r_out.region != REGION_DEAD))
        else $error("span fault flagged in the dead zone");

endmodule

// ===== src/axis_deadzone_scaler.sv =====
// axis_deadzone_scaler: top level, configuration registers and pipeline wiring.
// Depends on ads_pkg, ads_front, ads_div and ads_out.
// Pipeline: 7 + QUOT_W = 24 register stages (5 front-end stages, one divider stage per
//   quotient bit, sign stage and output register).
// Throughput: one sample per cycle while o_ready is high; the 17-stage divider sets the
//   depth. One skid entry takes the first result that meets a stalled output; o_ready is
//   low while it is held and rises as soon as it moves on to the output register.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
module axis_deadzone_scaler #(
    parameter int SAMPLE_BITS = ads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ads_pkg::OUT_W-1:0]     o_position,
    output logic [1:0]                           o_region,
    output logic                                 o_span_fault,
    input  logic                                 i_cfg_we,
    input  logic [ads_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ads_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ads_pkg::*;

    localparam int NUM_W = num_width(SAMPLE_BITS);

    // Configuration registers
    logic [SAMPLE_BITS-1:0]   r_in_low, r_in_high, r_dead;
    logic signed [OUT_W-1:0]  r_out_low, r_out_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_low   <= '0;
            r_in_high  <= SAMPLE_BITS'(IN_HIGH_RST);
            r_dead     <= '0;
            r_out_low  <= OUT_W'(OUT_LOW_RST);
            r_out_high <= OUT_W'(OUT_HIGH_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INPUT_LOW:       r_in_low   <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_INPUT_HIGH:      r_in_high  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_DEAD_HALF_WIDTH: r_dead     <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_OUTPUT_LOW:      r_out_low  <= $signed(i_cfg_data[OUT_W-1:0]);
                REG_OUTPUT_HIGH:     r_out_high <= $signed(i_cfg_data[OUT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Pipeline
    logic                    en;
    logic                    fr_valid, dv_valid;
    t_meta                   fr_meta, dv_meta;
    logic [NUM_W-1:0]        fr_mag;
    logic [SAMPLE_BITS:0]    fr_den;
    logic [QUOT_W-1:0]       dv_quo;
    t_result                 res;

    assign o_ready = en;

    ads_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .i_in_low   (r_in_low),
        .i_in_high  (r_in_high),
        .i_dead     (r_dead),
        .i_out_low  (r_out_low),
        .i_out_high (r_out_high),
        .o_valid    (fr_valid),
        .o_meta     (fr_meta),
        .o_mag      (fr_mag),
        .o_den      (fr_den)
    );

    ads_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_meta  (fr_meta),
        .i_mag   (fr_mag),
        .i_den   (fr_den),
        .o_valid (dv_valid),
        .o_meta  (dv_meta),
        .o_quo   (dv_quo)
    );

    ads_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (dv_valid),
        .i_meta     (dv_meta),
        .i_quo      (dv_quo),
        .i_out_low  (r_out_low),
        .i_out_high (r_out_high),
        .i_ready    (i_ready),
        .o_en       (en),
        .o_valid    (o_valid),
        .o_result   (res)
    );

    assign o_position   = res.position;
    assign o_region     = res.region;
    assign o_span_fault = res.span_fault;

endmodule
